>>> rtl/core/video_raster_output_with_pixel_fifo_core_macros.svh
// Assertion macros shared by the core RTL.
// Each check is clocked on the given clock and disabled while reset is high.
`ifndef VIDEO_RASTER_OUTPUT_WITH_PIXEL_FIFO_CORE_MACROS_SVH
`define VIDEO_RASTER_OUTPUT_WITH_PIXEL_FIFO_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define VROF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vrof assertion failed");
// Next-cycle implication.
`define VROF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vrof assertion failed");
`else
`define VROF_ASSERT_NOW(label, clk, rst, ante, cons)
`define VROF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/vrof_pkg.sv
package vrof_pkg;

   // Pixel FIFO geometry: the byte store is split into four byte lanes so
   // that all bytes of a whole word can be written together.
   localparam int FIFO_DEPTH = 4096;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FILL_W     = PTR_W + 1;
   localparam int LANES      = 4;
   localparam int LANE_W     = 2;
   localparam int ROW_DEPTH  = FIFO_DEPTH / LANES;
   localparam int ROW_W      = PTR_W - LANE_W;

   // Raster counters and register widths
   localparam int CNT_W    = 12;
   localparam int WIDTH_W  = 11;
   localparam int BLANK_W  = 10;
   localparam int PIXEL_W  = 8;
   localparam int WORD_W   = 32;
   localparam int FLAGS_W  = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [PIXEL_W-1:0] BLANK_PIXEL = 8'hBB;
   localparam logic [1:0]         PULSE_TICKS = 2'd3;

   // Register indexes on the csr channel
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_WIDTH  = 2'd0,
      CSR_ACTIVE_HEIGHT = 2'd1,
      CSR_LINE_BLANK    = 2'd2,
      CSR_FRAME_BLANK   = 2'd3
   } csr_index_type;

   // Raster sequencer state
   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_SCAN  = 3'b010,
      PH_PULSE = 3'b100
   } phase_type;

   // Control carried from the accept stage to the output register
   typedef struct packed {
      logic              pop;
      logic              blank;
      logic [LANE_W-1:0] lane;
      logic              line_act;
      logic              frame_act;
      logic              intr;
      logic              under;
      logic              ovf;
   } rsp_ctl_type;

   // Byte k of a word, first byte in the top bits
   function automatic logic [PIXEL_W-1:0] word_byte(input logic [WORD_W-1:0] word,
                                                    input logic [LANE_W-1:0] k);
      logic [PIXEL_W-1:0] b;
      unique case (k)
         2'd0: b = word[31:24];
         2'd1: b = word[23:16];
         2'd2: b = word[15:8];
         2'd3: b = word[7:0];
      endcase
      return b;
   endfunction

endpackage

>>> rtl/core/vrof_ram.sv
module vrof_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/video_raster_output_with_pixel_fifo_core.sv
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata pixel_word, tuser mode (1 word, 0 tick)
// rsp_      out  rsp_tvalid/rsp_tready  tdata pixel, tuser line/frame active and status flags
// csr_      in   csr_valid/csr_ready    csr_index register, csr_data value
//
// One transaction is taken per cycle while req_tready is high; a tick's result passes the
// RAM read and read stage, loaded at its accepting edge, and then the output register.
// A word writes up to four bytes together, one into each of four byte-lane RAMs.
// Reset clears pointers, counters and flags; the pixel store needs no clearing pass.
// req_tready falls only when both the read stage and the output register are full
// and rsp_tready is low; csr_ready is always high.
`include "video_raster_output_with_pixel_fifo_core_macros.svh"
module video_raster_output_with_pixel_fifo_core
   import vrof_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [WORD_W-1:0]    req_tdata,  // [31:0] pixel_word
   input  logic                 req_tuser,  // [0] mode
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PIXEL_W-1:0]   rsp_tdata,  // [7:0] pixel
   output logic [FLAGS_W-1:0]   rsp_tuser,  // [0] line active, [1] frame active,
                                            // [2] interrupt, [3] underflow, [4] overflow
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WIDTH_W-1:0]   csr_data
);

   // Configuration registers
   logic [WIDTH_W-1:0] active_width_ff, active_height_ff;
   logic [BLANK_W-1:0] line_blank_ff, frame_blank_ff;

   // FIFO state
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0] fill_count_ff, fill_count_in;
   logic              overflow_ff, overflow_in;

   // Raster state
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [1:0]        pulse_left_ff, pulse_left_in;
   logic [1:0]        last_valids_ff, last_valids_in;
   logic [PIXEL_W-1:0] last_pixel_ff;

   // Read stage and output register
   logic              s1_valid_ff, s1_valid_in;
   rsp_ctl_type       s1_ctl_ff, s1_ctl_in;
   logic              out_valid_ff;
   logic [PIXEL_W-1:0] out_pixel_ff;
   logic [FLAGS_W-1:0] out_flags_ff;

   logic              s1_adv, tick_acc, word_acc, pop;
   logic [FILL_W-1:0] space;
   logic [2:0]        n_wr;
   logic [CNT_W-1:0]  rows, cols, row_cur, col_cur, col_inc, row_inc;
   logic              frame_on, line_on;
   logic [PIXEL_W-1:0] rd_q [LANES];
   logic [PIXEL_W-1:0] pixel_res;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || !out_valid_ff || rsp_tready;
   assign tick_acc   = req_tvalid && req_tready && !req_tuser;
   assign word_acc   = req_tvalid && req_tready && req_tuser;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff  <= WIDTH_W'(640);
         active_height_ff <= WIDTH_W'(480);
         line_blank_ff    <= BLANK_W'(160);
         frame_blank_ff   <= BLANK_W'(40);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE_WIDTH:  active_width_ff  <= csr_data;
            CSR_ACTIVE_HEIGHT: active_height_ff <= csr_data;
            CSR_LINE_BLANK:    line_blank_ff    <= csr_data[BLANK_W-1:0];
            CSR_FRAME_BLANK:   frame_blank_ff   <= csr_data[BLANK_W-1:0];
         endcase
      end
   end

   // Free space and bytes that fit from one word
   assign space = FILL_W'(FIFO_DEPTH) - fill_count_ff;
   assign n_wr  = (space >= FILL_W'(LANES)) ? 3'(LANES) : space[2:0];

   // Byte lanes: byte k of a word goes to address wr_ptr + k
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [LANE_W-1:0] k;
      logic [PTR_W-1:0]  addr;
      logic              we;
      always_comb begin
         k    = LANE_W'(l) - wr_ptr_ff[LANE_W-1:0];
         addr = wr_ptr_ff + PTR_W'(k);
         we   = word_acc && ({1'b0, k} < n_wr);
      end
      vrof_ram #(
         .WIDTH (PIXEL_W),
         .DEPTH (ROW_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (addr[PTR_W-1:LANE_W]),
         .wr_data (word_byte(req_tdata, k)),
         .rd_en   (pop),
         .rd_addr (rd_ptr_ff[PTR_W-1:LANE_W]),
         .rd_data (rd_q[l])
      );
   end

   // Frame geometry; a zero total counts as one
   always_comb begin
      rows = CNT_W'(active_height_ff) + CNT_W'(frame_blank_ff);
      cols = CNT_W'(active_width_ff) + CNT_W'(line_blank_ff);
      if (rows == '0) begin
         rows = CNT_W'(1);
      end
      if (cols == '0) begin
         cols = CNT_W'(1);
      end
      row_cur  = (phase_ff == PH_SCAN) ? row_ff : '0;
      col_cur  = (phase_ff == PH_SCAN) ? col_ff : '0;
      col_inc  = col_cur + CNT_W'(1);
      row_inc  = row_cur + CNT_W'(1);
      frame_on = row_cur < CNT_W'(active_height_ff);
      line_on  = frame_on && (col_cur >= CNT_W'(line_blank_ff));
   end

   // Tick sequencing: pulse, idle hold, or one raster position
   always_comb begin
      phase_in       = phase_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      pulse_left_in  = pulse_left_ff;
      last_valids_in = last_valids_ff;
      pop            = 1'b0;
      s1_ctl_in      = '{pop: 1'b0, blank: 1'b0, lane: rd_ptr_ff[LANE_W-1:0],
                         line_act: last_valids_ff[0], frame_act: last_valids_ff[1],
                         intr: 1'b0, under: 1'b0, ovf: overflow_ff};
      if (tick_acc) begin
         unique case (phase_ff)
            PH_PULSE: begin
               if (pulse_left_ff != '0) begin
                  pulse_left_in = pulse_left_ff - 2'd1;
               end
               if (pulse_left_in == '0) begin
                  phase_in = PH_IDLE;
               end
               s1_ctl_in.intr = 1'b1;
            end
            default: begin
               if (phase_ff == PH_SCAN || fill_count_ff != '0) begin
                  phase_in = PH_SCAN;
                  if (line_on) begin
                     if (fill_count_ff == '0) begin
                        s1_ctl_in.under = 1'b1;
                     end else begin
                        pop           = 1'b1;
                        s1_ctl_in.pop = 1'b1;
                     end
                  end else begin
                     s1_ctl_in.blank = 1'b1;
                  end
                  last_valids_in      = {frame_on, line_on};
                  s1_ctl_in.line_act  = line_on;
                  s1_ctl_in.frame_act = frame_on;
                  // advance the raster position
                  col_in = col_inc;
                  row_in = row_cur;
                  if (col_inc >= cols) begin
                     col_in = '0;
                     row_in = row_inc;
                     if (row_inc >= rows) begin
                        row_in        = '0;
                        phase_in      = PH_PULSE;
                        pulse_left_in = PULSE_TICKS;
                     end
                  end
               end
            end
         endcase
      end
   end

   // FIFO pointer and fill update
   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      fill_count_in = fill_count_ff;
      overflow_in   = overflow_ff;
      if (word_acc) begin
         wr_ptr_in     = wr_ptr_ff + PTR_W'(n_wr);
         fill_count_in = fill_count_ff + FILL_W'(n_wr);
         if (n_wr != 3'(LANES)) begin
            overflow_in = 1'b1;
         end
      end else if (pop) begin
         rd_ptr_in     = rd_ptr_ff + PTR_W'(1);
         fill_count_in = fill_count_ff - FILL_W'(1);
      end
   end

   // Read stage occupancy
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (tick_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Pick the driven pixel once the lane data is out of the RAM
   assign pixel_res = s1_ctl_ff.pop   ? rd_q[s1_ctl_ff.lane] :
                      s1_ctl_ff.blank ? BLANK_PIXEL : last_pixel_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff      <= '0;
         wr_ptr_ff      <= '0;
         fill_count_ff  <= '0;
         overflow_ff    <= 1'b0;
         phase_ff       <= PH_IDLE;
         row_ff         <= '0;
         col_ff         <= '0;
         pulse_left_ff  <= '0;
         last_valids_ff <= '0;
         last_pixel_ff  <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         rd_ptr_ff      <= rd_ptr_in;
         wr_ptr_ff      <= wr_ptr_in;
         fill_count_ff  <= fill_count_in;
         overflow_ff    <= overflow_in;
         phase_ff       <= phase_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         pulse_left_ff  <= pulse_left_in;
         last_valids_ff <= last_valids_in;
         s1_valid_ff    <= s1_valid_in;
         if (s1_adv) begin
            last_pixel_ff <= pixel_res;
            out_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (tick_acc) begin
         s1_ctl_ff <= s1_ctl_in;
      end
      if (s1_adv) begin
         out_pixel_ff <= pixel_res;
         out_flags_ff <= {s1_ctl_ff.ovf, s1_ctl_ff.under, s1_ctl_ff.intr,
                          s1_ctl_ff.frame_act, s1_ctl_ff.line_act};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tuser  = out_flags_ff;

   `VROF_ASSERT_NOW(a_fill_range, clock, reset, 1'b1, fill_count_ff <= FILL_W'(FIFO_DEPTH))
   `VROF_ASSERT_NOW(a_ptr_coherent, clock, reset, 1'b1, PTR_W'(rd_ptr_ff + fill_count_ff[PTR_W-1:0]) == wr_ptr_ff)
   `VROF_ASSERT_NOW(a_pulse_count, clock, reset, phase_ff == PH_PULSE, pulse_left_ff != 2'd0)
   `VROF_ASSERT_NOW(a_under_active, clock, reset, rsp_tvalid && rsp_tuser[3], rsp_tuser[0] && !rsp_tuser[2])
   `VROF_ASSERT_NEXT(a_overflow_set, clock, reset, word_acc && (fill_count_ff == FILL_W'(FIFO_DEPTH)), overflow_ff)

endmodule
